// ===== rtl/sixteen_bit_isa_execute_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sixteen-bit ISA execute unit
// Short forms for clocked implication checks with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef SIXTEEN_BIT_ISA_EXECUTE_UNIT_MACROS_SVH
`define SIXTEEN_BIT_ISA_EXECUTE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBIE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBIE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sbie_pkg.sv =====
// ----------------------------------------------------------------------------
// sbie_pkg
// Opcodes, fixed register and PC constants and shared structures of the execute unit.
// ----------------------------------------------------------------------------
package sbie_pkg;

  localparam logic [5:0] OP_ADD    = 6'd0;
  localparam logic [5:0] OP_ADDU   = 6'd1;
  localparam logic [5:0] OP_SUB    = 6'd2;
  localparam logic [5:0] OP_AND    = 6'd3;
  localparam logic [5:0] OP_OR     = 6'd4;
  localparam logic [5:0] OP_ADDI   = 6'd5;
  localparam logic [5:0] OP_LOAD   = 6'd6;
  localparam logic [5:0] OP_STW    = 6'd7;
  localparam logic [5:0] OP_BITOP  = 6'd8;
  localparam logic [5:0] OP_BZ     = 6'd9;
  localparam logic [5:0] OP_JAL    = 6'd10;
  localparam logic [5:0] OP_JR     = 6'd11;
  localparam logic [5:0] OP_SHL    = 6'd12;
  localparam logic [5:0] OP_SAR    = 6'd13;
  localparam logic [5:0] OP_MOV    = 6'd14;

  localparam logic [4:0]  LINK_REG  = 5'd31;
  localparam int unsigned NUM_REGS  = 32;
  localparam logic [31:0] PC_STEP   = 32'd2;

  // Control and status of one instruction, as produced by the execute logic.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic        mem_write;
    logic        mem_read;
    logic        branch_taken;
    logic        unknown_opcode;
  } sbie_ctl_t;

  // One result transaction at the output ports.
  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_write;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        mem_write;
    logic [9:0]  mem_address;
    logic [31:0] mem_value;
    logic        branch_taken;
    logic        unknown_opcode;
  } sbie_out_t;

endpackage

// ===== rtl/sbie_ram.sv =====
// ----------------------------------------------------------------------------
// sbie_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module sbie_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read in the same cycle as a write to the same entry returns old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sbie_alu.sv =====
// ----------------------------------------------------------------------------
// sbie_alu
// Decode and execute of one instruction against its operands and the PC.
// ----------------------------------------------------------------------------
module sbie_alu #(
  parameter int WORD_WIDTH = 32,
  parameter int MEM_WORDS  = 1024
) (
  input  logic [15:0]                  inst,
  input  logic [WORD_WIDTH-1:0]        a_val,
  input  logic [WORD_WIDTH-1:0]        b_val,
  input  logic [31:0]                  pc,
  output sbie_pkg::sbie_ctl_t          ctl,
  output logic [WORD_WIDTH-1:0]        value,
  output logic [$clog2(MEM_WORDS)-1:0] mem_addr,
  output logic [WORD_WIDTH-1:0]        store_data
);

  localparam int AW = $clog2(MEM_WORDS);

  logic [5:0]            op;
  logic [4:0]            ra;
  logic [4:0]            rb;
  logic [3:0]            bit_num;
  logic [WORD_WIDTH-1:0] imm_sext;
  logic [WORD_WIDTH-1:0] bit_mask;
  logic [31:0]           pc_plus2;
  logic [31:0]           bz_offset;
  logic [WORD_WIDTH-1:0] link_val;

  assign op        = inst[15:10];
  assign ra        = inst[9:5];
  assign rb        = inst[4:0];
  assign bit_num   = rb[3:0];
  assign imm_sext  = {{(WORD_WIDTH-5){rb[4]}}, rb};
  assign bit_mask  = {{(WORD_WIDTH-1){1'b0}}, 1'b1} << (bit_num - 4'd1);
  assign pc_plus2  = pc + sbie_pkg::PC_STEP;
  assign bz_offset = {{26{rb[4]}}, rb, 1'b0};
  assign link_val  = WORD_WIDTH'(pc_plus2);
  // The memory depth is a power of two, so the word index is the low bits.
  assign mem_addr  = b_val[AW-1:0];

  always_comb begin
    ctl                = '0;
    ctl.next_pc        = pc_plus2;
    value              = '0;
    store_data         = '0;
    unique case (op) inside
      sbie_pkg::OP_ADD, sbie_pkg::OP_ADDU: begin
        value         = a_val + b_val;
        ctl.reg_write = 1'b1;
      end
      sbie_pkg::OP_SUB: begin
        value         = a_val - b_val;
        ctl.reg_write = 1'b1;
      end
      sbie_pkg::OP_AND: begin
        value         = a_val & b_val;
        ctl.reg_write = 1'b1;
      end
      sbie_pkg::OP_OR: begin
        value         = a_val | b_val;
        ctl.reg_write = 1'b1;
      end
      sbie_pkg::OP_ADDI: begin
        value         = a_val + imm_sext;
        ctl.reg_write = 1'b1;
      end
      sbie_pkg::OP_LOAD: begin
        ctl.reg_write = 1'b1;
        ctl.mem_read  = 1'b1;
      end
      sbie_pkg::OP_STW: begin
        ctl.mem_write = 1'b1;
        store_data    = a_val;
      end
      sbie_pkg::OP_BITOP: begin
        // A zero bit number writes the register back unchanged.
        if (bit_num == 4'd0) begin
          value = a_val;
        end else if (rb[4]) begin
          value = a_val | bit_mask;
        end else begin
          value = a_val & ~bit_mask;
        end
        ctl.reg_write = 1'b1;
      end
      sbie_pkg::OP_BZ: begin
        if (a_val == '0) begin
          ctl.branch_taken = 1'b1;
          ctl.next_pc      = pc + bz_offset;
        end
      end
      sbie_pkg::OP_JAL: begin
        // The target is read after the link write, so A = r31 jumps to PC + 2.
        value            = link_val;
        ctl.reg_write    = 1'b1;
        ctl.branch_taken = 1'b1;
        ctl.next_pc      = (ra == sbie_pkg::LINK_REG) ? 32'(link_val) : 32'(a_val);
      end
      sbie_pkg::OP_JR: begin
        ctl.branch_taken = 1'b1;
        ctl.next_pc      = 32'(a_val);
      end
      sbie_pkg::OP_SHL: begin
        value         = a_val << rb;
        ctl.reg_write = 1'b1;
      end
      sbie_pkg::OP_SAR: begin
        value         = $unsigned($signed(a_val) >>> rb);
        ctl.reg_write = 1'b1;
      end
      sbie_pkg::OP_MOV: begin
        value         = b_val;
        ctl.reg_write = 1'b1;
      end
      default: begin
        ctl.unknown_opcode = 1'b1;
      end
    endcase
    if (ctl.reg_write) begin
      ctl.reg_index = (op == sbie_pkg::OP_JAL) ? sbie_pkg::LINK_REG : ra;
    end
  end

endmodule

// ===== rtl/sbie_skid.sv =====
// ----------------------------------------------------------------------------
// sbie_skid
// Output register with one skid entry, so that ready upstream is registered.
// ----------------------------------------------------------------------------
module sbie_skid (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  sbie_pkg::sbie_out_t push_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sbie_pkg::sbie_out_t out_data
);

  logic                out_valid_r;
  logic                skid_valid_r;
  sbie_pkg::sbie_out_t out_data_r;
  sbie_pkg::sbie_out_t skid_data_r;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= push_valid;
      end
    end else if (push_valid && !skid_valid_r) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !out_valid_r) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (push_valid) begin
        out_data_r <= push_data;
      end
    end else if (push_valid && !skid_valid_r) begin
      skid_data_r <= push_data;
    end
  end

endmodule

// ===== rtl/sixteen_bit_isa_execute_unit.sv =====
// ----------------------------------------------------------------------------
// Sixteen-bit ISA execute unit
// Executes one 16-bit instruction per transaction and reports its effects.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_ready, in_instruction) takes one instruction
// word per transaction. The output channel (out_valid, out_ready, out_*) gives
// one result transaction per instruction, in order: the new PC, the register
// write, the memory write, whether a branch or jump was taken and whether the
// opcode was unknown.
// An accepted instruction is registered into execute and executed there, finishes
// its load access in the memory stage and is then registered in the output
// register for the receiver. The unit takes one instruction every cycle while
// in_ready is high; the register file is read as the instruction is accepted
// and results still in flight are forwarded, so dependent instructions need
// no bubbles.
// After reset the data memory is swept to zero, one word per cycle, over all
// MEM_WORDS words (1024 by default); in_ready stays low during the sweep. The
// register file and the PC start at zero at once.
// When the receiver stalls, the output register holds its result and one more
// result is caught in a skid entry; in_ready then drops until the skid entry
// drains. in_ready never depends combinationally on out_ready.
// ----------------------------------------------------------------------------
`include "sixteen_bit_isa_execute_unit_macros.svh"

module sixteen_bit_isa_execute_unit #(
  parameter int WORD_WIDTH = 32,
  parameter int MEM_WORDS  = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [15:0]        in_instruction,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_next_pc,
  output logic               out_reg_write,
  output logic [4:0]         out_reg_index,
  output logic signed [31:0] out_reg_value,
  output logic               out_mem_write,
  output logic [9:0]         out_mem_address,
  output logic signed [31:0] out_mem_value,
  output logic               out_branch_taken,
  output logic               out_unknown_opcode
);

  // MEM_WORDS must be a power of two: the word index is the low address bits.
  localparam int AW = $clog2(MEM_WORDS);

  // Pipeline control. The whole pipeline moves when the skid entry is free.
  logic adv;
  logic accept;
  logic e_retire;
  logic wb_fire;

  // Data memory sweep after reset.
  logic          clearing_r;
  logic [AW-1:0] clr_cnt_r;

  // Execute stage.
  logic                  e_valid_r;
  logic [15:0]           e_inst_r;
  logic [31:0]           pc_r;
  logic [WORD_WIDTH-1:0] rf_a_rdata;
  logic [WORD_WIDTH-1:0] rf_b_rdata;
  logic [WORD_WIDTH-1:0] a_fwd;
  logic [WORD_WIDTH-1:0] b_fwd;
  sbie_pkg::sbie_ctl_t   e_ctl;
  logic [WORD_WIDTH-1:0] e_value;
  logic [AW-1:0]         e_maddr;
  logic [WORD_WIDTH-1:0] e_sdata;

  // Memory stage.
  logic                  m_valid_r;
  sbie_pkg::sbie_ctl_t   m_ctl_r;
  logic [WORD_WIDTH-1:0] m_value_r;
  logic [AW-1:0]         m_maddr_r;
  logic [WORD_WIDTH-1:0] m_sdata_r;
  logic [WORD_WIDTH-1:0] m_result;
  logic [WORD_WIDTH-1:0] dmem_rdata;

  // Last register write, kept for the instruction whose read saw old data.
  logic                  wb_valid_r;
  logic [4:0]            wb_idx_r;
  logic [WORD_WIDTH-1:0] wb_val_r;
  logic [sbie_pkg::NUM_REGS-1:0] rf_valid_r;

  // Data memory port.
  logic                  dmem_we;
  logic [AW-1:0]         dmem_waddr;
  logic [WORD_WIDTH-1:0] dmem_wdata;
  logic                  dmem_re;

  sbie_pkg::sbie_out_t   push_data;
  sbie_pkg::sbie_out_t   out_data;

  assign accept   = in_valid && in_ready;
  assign in_ready = adv && !clearing_r;
  assign e_retire = adv && e_valid_r;
  assign wb_fire  = adv && m_valid_r && m_ctl_r.reg_write;

  // --------------------------------------------------------------------------
  // Register file: two copies written together, one per read port. Both are
  // read with the fields of the word on the input ports whenever the pipeline
  // moves, so the data lines up with the instruction entering execute.
  // --------------------------------------------------------------------------
  sbie_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (sbie_pkg::NUM_REGS)
  ) u_rf_a (
    .clk   (clk),
    .we    (wb_fire),
    .waddr (m_ctl_r.reg_index),
    .wdata (m_result),
    .re    (adv),
    .raddr (in_instruction[9:5]),
    .rdata (rf_a_rdata)
  );

  sbie_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (sbie_pkg::NUM_REGS)
  ) u_rf_b (
    .clk   (clk),
    .we    (wb_fire),
    .waddr (m_ctl_r.reg_index),
    .wdata (m_result),
    .re    (adv),
    .raddr (in_instruction[4:0]),
    .rdata (rf_b_rdata)
  );

  // Operand selection: the instruction in the memory stage is youngest, then
  // the write made as this instruction was read, then the array. A register
  // never written since reset reads as zero.
  always_comb begin
    if (m_valid_r && m_ctl_r.reg_write && (m_ctl_r.reg_index == e_inst_r[9:5])) begin
      a_fwd = m_result;
    end else if (wb_valid_r && (wb_idx_r == e_inst_r[9:5])) begin
      a_fwd = wb_val_r;
    end else if (rf_valid_r[e_inst_r[9:5]]) begin
      a_fwd = rf_a_rdata;
    end else begin
      a_fwd = '0;
    end
  end

  always_comb begin
    if (m_valid_r && m_ctl_r.reg_write && (m_ctl_r.reg_index == e_inst_r[4:0])) begin
      b_fwd = m_result;
    end else if (wb_valid_r && (wb_idx_r == e_inst_r[4:0])) begin
      b_fwd = wb_val_r;
    end else if (rf_valid_r[e_inst_r[4:0]]) begin
      b_fwd = rf_b_rdata;
    end else begin
      b_fwd = '0;
    end
  end

  sbie_alu #(
    .WORD_WIDTH (WORD_WIDTH),
    .MEM_WORDS  (MEM_WORDS)
  ) u_alu (
    .inst       (e_inst_r),
    .a_val      (a_fwd),
    .b_val      (b_fwd),
    .pc         (pc_r),
    .ctl        (e_ctl),
    .value      (e_value),
    .mem_addr   (e_maddr),
    .store_data (e_sdata)
  );

  // --------------------------------------------------------------------------
  // Data memory. Stores write as they leave execute, loads issue their read
  // there and pick up the data in the memory stage. Only one instruction is
  // ever in execute, so a load always sees every earlier store.
  // --------------------------------------------------------------------------
  assign dmem_we    = clearing_r || (e_retire && e_ctl.mem_write);
  assign dmem_waddr = clearing_r ? clr_cnt_r : e_maddr;
  assign dmem_wdata = clearing_r ? '0 : e_sdata;
  assign dmem_re    = e_retire && e_ctl.mem_read;

  sbie_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (MEM_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (dmem_we),
    .waddr (dmem_waddr),
    .wdata (dmem_wdata),
    .re    (dmem_re),
    .raddr (e_maddr),
    .rdata (dmem_rdata)
  );

  assign m_result = m_ctl_r.mem_read ? dmem_rdata : m_value_r;

  // Sweep counter: one word per cycle from reset until the last word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
      if (clr_cnt_r == AW'(MEM_WORDS - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  // Pipeline valid bits, PC and register-file bookkeeping.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_valid_r  <= 1'b0;
      m_valid_r  <= 1'b0;
      pc_r       <= '0;
      wb_valid_r <= 1'b0;
      rf_valid_r <= '0;
    end else begin
      if (adv) begin
        e_valid_r <= accept;
        m_valid_r <= e_valid_r;
      end
      if (e_retire) begin
        pc_r <= e_ctl.next_pc;
      end
      if (wb_fire) begin
        wb_valid_r                     <= 1'b1;
        rf_valid_r[m_ctl_r.reg_index] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      e_inst_r <= in_instruction;
    end
    if (e_retire) begin
      m_ctl_r   <= e_ctl;
      m_value_r <= e_value;
      m_maddr_r <= e_maddr;
      m_sdata_r <= e_sdata;
    end
    if (wb_fire) begin
      wb_idx_r <= m_ctl_r.reg_index;
      wb_val_r <= m_result;
    end
  end

  // --------------------------------------------------------------------------
  // Result transaction and output stage.
  // --------------------------------------------------------------------------
  always_comb begin
    push_data                = '0;
    push_data.next_pc        = m_ctl_r.next_pc;
    push_data.reg_write      = m_ctl_r.reg_write;
    push_data.reg_index      = m_ctl_r.reg_index;
    push_data.reg_value      = 32'(m_result);
    push_data.mem_write      = m_ctl_r.mem_write;
    push_data.mem_address    = m_ctl_r.mem_write ? 10'(m_maddr_r) : 10'd0;
    push_data.mem_value      = 32'(m_sdata_r);
    push_data.branch_taken   = m_ctl_r.branch_taken;
    push_data.unknown_opcode = m_ctl_r.unknown_opcode;
  end

  sbie_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (m_valid_r),
    .push_ready (adv),
    .push_data  (push_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_next_pc        = out_data.next_pc;
  assign out_reg_write      = out_data.reg_write;
  assign out_reg_index      = out_data.reg_index;
  assign out_reg_value      = $signed(out_data.reg_value);
  assign out_mem_write      = out_data.mem_write;
  assign out_mem_address    = out_data.mem_address;
  assign out_mem_value      = $signed(out_data.mem_value);
  assign out_branch_taken   = out_data.branch_taken;
  assign out_unknown_opcode = out_data.unknown_opcode;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  `SBIE_ASSERT_SAME(a_no_accept_in_sweep, clk, rst_n, clearing_r, !in_ready,
    "instruction accepted during the data memory sweep")
  `SBIE_ASSERT_SAME(a_stall_has_output, clk, rst_n, !adv, out_valid,
    "pipeline stalled without a result waiting at the output")
  `SBIE_ASSERT_SAME(a_dmem_write_source, clk, rst_n, dmem_we && !clearing_r,
    e_retire && e_ctl.mem_write, "data memory written without a retiring store")
  `SBIE_ASSERT_NEXT(a_pc_holds, clk, rst_n, !e_retire, $stable(pc_r),
    "PC changed without an instruction leaving execute")

endmodule
